FILE: src/tcfp_pkg.sv
// Shared types and constants for the tilemap cell fetch and place block.
`timescale 1ns / 1ps
package tcfp_pkg;

	// Tile RAM geometry
	localparam int RAM_AW    = 15;
	localparam int RAM_WORDS = 32768;

	// Queue depths between the parts
	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_DEPTH   = 4;

	// Item operations
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_RENDER = 1'b1;

	// Draw modes
	localparam logic [1:0] DRAW_NONE = 2'd0;
	localparam logic [1:0] DRAW_FULL = 2'd1;
	localparam logic [1:0] DRAW_CLIP = 2'd2;

	// Register indexes
	localparam logic [2:0] REG_PAGE_SELECT     = 3'd0;
	localparam logic [2:0] REG_SCROLL_H        = 3'd1;
	localparam logic [2:0] REG_SCROLL_V        = 3'd2;
	localparam logic [2:0] REG_ALT_SCROLL_H    = 3'd3;
	localparam logic [2:0] REG_ALT_SCROLL_V    = 3'd4;
	localparam logic [2:0] REG_CLAMP_OFFSET    = 3'd5;
	localparam logic [2:0] REG_VISIBLE_WIDTH   = 3'd6;
	localparam logic [2:0] REG_BANK_MAP        = 3'd7;

	// Register reset values
	localparam logic [9:0] RESET_CLAMP_OFFSET  = 10'd192;
	localparam logic [9:0] RESET_VISIBLE_WIDTH = 10'd320;
	localparam logic [7:0] RESET_BANK_MAP      = 8'd16;

	typedef struct packed {
		logic [15:0] page_select;
		logic [15:0] scroll_horizontal;
		logic [15:0] scroll_vertical;
		logic [15:0] alt_scroll_horizontal;
		logic [15:0] alt_scroll_vertical;
		logic [9:0]  clamp_offset;
		logic [9:0]  visible_width;
		logic [7:0]  bank_map;
	} cfg_t;

	// Classified beat handed from the front to the back
	typedef struct packed {
		logic              operation;
		logic [14:0]       word_address;
		logic [15:0]       write_data;
		logic              wanted_priority;
		logic [1:0]        draw_mode;
		logic signed [10:0] screen_x;
		logic signed [9:0]  screen_y;
	} job_t;

	typedef struct packed {
		logic [1:0]        draw_mode;
		logic [12:0]       tile_code;
		logic [6:0]        palette_index;
		logic [1:0]        palette_bank;
		logic signed [10:0] screen_x;
		logic signed [9:0]  screen_y;
	} result_t;

endpackage

FILE: src/tilemap_cell_fetch_and_place.sv
// Top level of the tilemap cell fetch and place block: config registers and part wiring.
// Path: an accepted beat passes the front register, the job queue, the back's
// tile RAM read register and the result queue before it reaches the result ports.
// Throughput: one beat per cycle unless a side stalls; one tile RAM access per beat.
// Short FIFOs after the front and before the result port let each side stall alone.
// Reset: arst_n clears control state and loads the config registers with their
// defaults; tile RAM contents are undefined until written.
`timescale 1ns / 1ps
module tilemap_cell_fetch_and_place #(
	parameter int TILE_COUNT    = 8192,
	parameter int SCREEN_HEIGHT = 224
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               operation,
	input  logic [14:0]        word_address,
	input  logic [15:0]        write_data,
	input  logic [5:0]         cell_row,
	input  logic [6:0]         cell_column,
	input  logic               wanted_priority,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         draw_mode,
	output logic [12:0]        tile_code,
	output logic [6:0]         palette_index,
	output logic [1:0]         palette_bank,
	output logic signed [10:0] screen_x,
	output logic signed [9:0]  screen_y,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import tcfp_pkg::*;

	localparam int JOB_W = $bits(job_t);
	localparam int RES_W = $bits(result_t);

	cfg_t    cfg_q;
	logic    jq_push;
	job_t    jq_din;
	logic    jq_full;
	logic    jq_pop;
	logic    jq_empty;
	logic [JOB_W-1:0] jq_dout;
	job_t    jq_job;
	logic    rq_push;
	result_t rq_din;
	logic [RES_W-1:0] rq_dout;
	result_t rq_res;
	logic [$clog2(OUT_DEPTH):0] rq_count;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.page_select           <= '0;
			cfg_q.scroll_horizontal     <= '0;
			cfg_q.scroll_vertical       <= '0;
			cfg_q.alt_scroll_horizontal <= '0;
			cfg_q.alt_scroll_vertical   <= '0;
			cfg_q.clamp_offset          <= RESET_CLAMP_OFFSET;
			cfg_q.visible_width         <= RESET_VISIBLE_WIDTH;
			cfg_q.bank_map              <= RESET_BANK_MAP;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PAGE_SELECT:   cfg_q.page_select           <= cfg_data;
				REG_SCROLL_H:      cfg_q.scroll_horizontal     <= cfg_data;
				REG_SCROLL_V:      cfg_q.scroll_vertical       <= cfg_data;
				REG_ALT_SCROLL_H:  cfg_q.alt_scroll_horizontal <= cfg_data;
				REG_ALT_SCROLL_V:  cfg_q.alt_scroll_vertical   <= cfg_data;
				REG_CLAMP_OFFSET:  cfg_q.clamp_offset          <= cfg_data[9:0];
				REG_VISIBLE_WIDTH: cfg_q.visible_width         <= cfg_data[9:0];
				REG_BANK_MAP:      cfg_q.bank_map              <= cfg_data[7:0];
				default:           ;
			endcase
		end
	end

	tcfp_front #(
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.push            (push),
		.full            (full),
		.operation       (operation),
		.word_address    (word_address),
		.write_data      (write_data),
		.cell_row        (cell_row),
		.cell_column     (cell_column),
		.wanted_priority (wanted_priority),
		.q_push          (jq_push),
		.q_job           (jq_din),
		.q_full          (jq_full)
	);

	// queue between front and back
	tcfp_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (jq_push),
		.din    (jq_din),
		.full   (jq_full),
		.pop    (jq_pop),
		.dout   (jq_dout),
		.empty  (jq_empty),
		.count  ()
	);

	assign jq_job = jq_dout;

	tcfp_back #(
		.TILE_COUNT (TILE_COUNT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.bank_map (cfg_q.bank_map),
		.q_empty  (jq_empty),
		.q_job    (jq_job),
		.q_pop    (jq_pop),
		.o_count  (rq_count),
		.o_push   (rq_push),
		.o_res    (rq_din)
	);

	// result queue
	tcfp_fifo #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.din    (rq_din),
		.full   (),
		.pop    (pop),
		.dout   (rq_dout),
		.empty  (empty),
		.count  (rq_count)
	);

	assign rq_res        = rq_dout;
	assign draw_mode     = rq_res.draw_mode;
	assign tile_code     = rq_res.tile_code;
	assign palette_index = rq_res.palette_index;
	assign palette_bank  = rq_res.palette_bank;
	assign screen_x      = rq_res.screen_x;
	assign screen_y      = rq_res.screen_y;

endmodule

FILE: src/tcfp_fifo.sv
// Small register FIFO used between the front, the back and the result port.
`timescale 1ns / 1ps
module tcfp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           din,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           dout,
	output logic                       empty,
	output logic [$clog2(DEPTH):0]     count
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign dout    = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= din;
	end

endmodule

FILE: src/tcfp_front.sv
// Front part: takes input beats, forms the tile RAM address and places the cell on screen.
`timescale 1ns / 1ps
module tcfp_front #(
	parameter int SCREEN_HEIGHT = 224
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tcfp_pkg::cfg_t      cfg,
	input  logic                push,
	output logic                full,
	input  logic                operation,
	input  logic [14:0]         word_address,
	input  logic [15:0]         write_data,
	input  logic [5:0]          cell_row,
	input  logic [6:0]          cell_column,
	input  logic                wanted_priority,
	output logic                q_push,
	output tcfp_pkg::job_t      q_job,
	input  logic                q_full
);
	import tcfp_pkg::*;

	localparam logic signed [11:0] SCR_H = 12'(SCREEN_HEIGHT);

	logic                valid_s1;
	logic                op_s1;
	logic [14:0]         addr_s1;
	logic [15:0]         wdata_s1;
	logic                prio_s1;
	logic signed [11:0]  x_pre_s1;
	logic signed [10:0]  y_pre_s1;

	logic                advance;
	logic [3:0]          page;
	logic [14:0]         addr;
	logic [15:0]         xs;
	logic [15:0]         ys;
	logic [9:0]          x_delta;
	logic signed [11:0]  x_pre;
	logic signed [10:0]  y_pre;
	logic signed [11:0]  neg_clamp;
	logic signed [11:0]  x_w;
	logic signed [10:0]  y_w;
	logic signed [11:0]  y_ext;
	logic signed [11:0]  vis_w;
	logic [1:0]          mode;

	assign advance = !valid_s1 || !q_full;
	assign full    = !advance;
	assign q_push  = valid_s1 && !q_full;

	// quadrant picks the page nibble
	always_comb begin
		unique case ({cell_row[5], cell_column[6]})
			2'b00: page = cfg.page_select[3:0];
			2'b01: page = cfg.page_select[7:4];
			2'b10: page = cfg.page_select[11:8];
			2'b11: page = cfg.page_select[15:12];
		endcase
	end

	assign addr = (operation == OP_WRITE) ? word_address
		: {page, cell_row[4:0], cell_column[5:0]};

	// raw placement before wrap
	assign xs      = cfg.scroll_horizontal[15] ? cfg.alt_scroll_horizontal : cfg.scroll_horizontal;
	assign ys      = cfg.scroll_vertical[15] ? cfg.alt_scroll_vertical : cfg.scroll_vertical;
	assign x_delta = cfg.clamp_offset - xs[9:0];
	assign x_pre   = $signed({2'b00, cell_column, 3'b000}) - $signed({2'b00, x_delta});
	assign y_pre   = $signed({2'b00, cell_row, 3'b000}) - $signed({2'b00, ys[8:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && advance) begin
			op_s1    <= operation;
			addr_s1  <= addr;
			wdata_s1 <= write_data;
			prio_s1  <= wanted_priority;
			x_pre_s1 <= x_pre;
			y_pre_s1 <= y_pre;
		end
	end

	// wrap and clip classification
	assign neg_clamp = 12'sd0 - $signed({2'b00, cfg.clamp_offset});
	assign x_w   = (x_pre_s1 < neg_clamp) ? x_pre_s1 + 12'sd1024 : x_pre_s1;
	assign y_w   = (y_pre_s1 < -11'sd288) ? y_pre_s1 + 11'sd512 : y_pre_s1;
	assign y_ext = 12'(y_w);
	assign vis_w = $signed({2'b00, cfg.visible_width});

	always_comb begin
		if (x_w > 12'sd7 && x_w < vis_w - 12'sd8 && y_ext > 12'sd7 && y_ext <= SCR_H - 12'sd8)
			mode = DRAW_FULL;
		else if (x_w > -12'sd8 && x_w < vis_w && y_ext > -12'sd8 && y_ext < SCR_H)
			mode = DRAW_CLIP;
		else
			mode = DRAW_NONE;
	end

	always_comb begin
		q_job.operation       = op_s1;
		q_job.word_address    = addr_s1;
		q_job.write_data      = wdata_s1;
		q_job.wanted_priority = prio_s1;
		q_job.draw_mode       = mode;
		q_job.screen_x        = x_w[10:0];
		q_job.screen_y        = y_w[9:0];
	end

endmodule

FILE: src/tcfp_back.sv
// Back part: tile RAM access, priority filter, code remap and result forming.
`timescale 1ns / 1ps
module tcfp_back #(
	parameter int TILE_COUNT = 8192
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [7:0]                          bank_map,
	input  logic                                q_empty,
	input  tcfp_pkg::job_t                      q_job,
	output logic                                q_pop,
	input  logic [$clog2(tcfp_pkg::OUT_DEPTH):0] o_count,
	output logic                                o_push,
	output tcfp_pkg::result_t                   o_res
);
	import tcfp_pkg::*;

	localparam int          CW        = $clog2(OUT_DEPTH) + 2;
	localparam logic [15:0] CODE_MASK = 16'(TILE_COUNT - 1);

	logic [15:0] map_mem [RAM_WORDS];
	logic [15:0] rdata_s1;
	job_t        job_s1;
	logic        valid_s1;

	logic        room;
	logic [3:0]  bank;
	logic [15:0] code;
	logic        keep;
	logic [6:0]  colour;

	// results in flight plus those queued must fit the output FIFO
	assign room  = (CW'(o_count) + CW'(valid_s1)) < CW'(OUT_DEPTH);
	assign q_pop = !q_empty && room;

	// tile RAM write port
	always_ff @(posedge clk) begin
		if (q_pop && q_job.operation == OP_WRITE)
			map_mem[q_job.word_address] <= q_job.write_data;
	end

	// tile RAM read port, registered; only render beats read
	always_ff @(posedge clk) begin
		if (q_pop && q_job.operation == OP_RENDER) rdata_s1 <= map_mem[q_job.word_address];
	end

	always_ff @(posedge clk) begin
		if (q_pop) job_s1 <= q_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else         valid_s1 <= q_pop;
	end

	// remap and filter
	assign bank   = rdata_s1[12] ? bank_map[7:4] : bank_map[3:0];
	assign code   = {bank, rdata_s1[11:0]} & CODE_MASK;
	assign colour = rdata_s1[12:6];
	assign keep   = (job_s1.operation == OP_RENDER) && (rdata_s1[15] == job_s1.wanted_priority)
		&& (code != 16'd0) && (job_s1.draw_mode != DRAW_NONE);

	assign o_push = valid_s1;

	always_comb begin
		o_res = '0;
		if (keep) begin
			o_res.draw_mode     = job_s1.draw_mode;
			o_res.tile_code     = code[12:0];
			o_res.palette_index = colour;
			o_res.palette_bank  = colour[6:5];
			o_res.screen_x      = job_s1.screen_x;
			o_res.screen_y      = job_s1.screen_y;
		end
	end

	// credit scheme never overfills the result FIFO
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (CW'(o_count) < CW'(OUT_DEPTH)))
		else $error("result FIFO overflow");

	a_write_draws_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && job_s1.operation == OP_WRITE) |-> (o_res.draw_mode == DRAW_NONE))
		else $error("write beat produced a drawn tile");

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && o_res.draw_mode == DRAW_NONE) |-> (o_res == '0))
		else $error("undrawn result carries nonzero fields");

	a_pop_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> valid_s1)
		else $error("popped beat lost before result stage");

endmodule

FILE: dv/tb_tilemap_cell_fetch_and_place.sv
// Self-checking testbench for the tilemap cell fetch and place block.
`timescale 1ns / 1ps
module tb_tilemap_cell_fetch_and_place;
	import tcfp_pkg::*;

	localparam int TILE_COUNT     = 8192;
	localparam int SCREEN_HEIGHT  = 224;
	localparam int PHASES         = 8;
	localparam int RAND_PER_PHASE = 205;
	localparam int LIMIT_CYCLES   = 400000;
	localparam int DIR_ROWS       = 18;

	// One input beat, as driven on the payload ports
	typedef struct packed {
		logic        operation;
		logic [14:0] word_address;
		logic [15:0] write_data;
		logic [5:0]  cell_row;
		logic [6:0]  cell_column;
		logic        wanted_priority;
	} cell_beat_t;

	// Directed row: beat plus a hand-written result where one is given
	typedef struct {
		cell_beat_t beat;
		bit         typed;
		result_t    want;
	} dir_row_t;

	localparam result_t NO_DRAW = '0;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic               operation;
	logic [14:0]        word_address;
	logic [15:0]        write_data;
	logic [5:0]         cell_row;
	logic [6:0]         cell_column;
	logic               wanted_priority;
	logic               empty;
	logic               pop;
	logic [1:0]         draw_mode;
	logic [12:0]        tile_code;
	logic [6:0]         palette_index;
	logic [1:0]         palette_bank;
	logic signed [10:0] screen_x;
	logic signed [9:0]  screen_y;
	logic               cfg_write;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;

	// Shadow of the block: tile RAM, written flags, registers
	logic [15:0] map_words_copy [0:RAM_WORDS-1];
	bit          word_written [0:RAM_WORDS-1];
	cfg_t        cfg_copy;

	result_t pending_results [$];
	int      beats_sent;
	int      mismatch_count;
	int      cycle_count;
	int      send_idle_pct;
	int      stall_pct;
	int      hold_len;

	// Reset defaults first, then priority, code zero, bank remap, extremes and clipping
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{'{OP_WRITE,  15'd89,    16'h0041, 6'd0,  7'd0,   1'b0}, 1'b1, NO_DRAW},
		'{'{OP_RENDER, 15'd0,     16'h0000, 6'd1,  7'd25,  1'b0}, 1'b1,
			'{DRAW_FULL, 13'h041, 7'd1, 2'd0, 11'sd8, 10'sd8}},
		'{'{OP_RENDER, 15'd0,     16'h0000, 6'd1,  7'd25,  1'b1}, 1'b1, NO_DRAW},
		'{'{OP_WRITE,  15'd90,    16'h0000, 6'd0,  7'd0,   1'b0}, 1'b1, NO_DRAW},
		'{'{OP_RENDER, 15'd0,     16'h0000, 6'd1,  7'd26,  1'b0}, 1'b1, NO_DRAW},
		'{'{OP_WRITE,  15'd91,    16'h1000, 6'd0,  7'd0,   1'b0}, 1'b0, NO_DRAW},
		'{'{OP_RENDER, 15'd0,     16'h0000, 6'd1,  7'd27,  1'b0}, 1'b0, NO_DRAW},
		'{'{OP_WRITE,  15'd2047,  16'hffff, 6'd0,  7'd0,   1'b0}, 1'b0, NO_DRAW},
		'{'{OP_RENDER, 15'd0,     16'h0000, 6'd63, 7'd127, 1'b1}, 1'b0, NO_DRAW},
		'{'{OP_WRITE,  15'd0,     16'h8123, 6'd0,  7'd0,   1'b0}, 1'b0, NO_DRAW},
		'{'{OP_RENDER, 15'd0,     16'h0000, 6'd0,  7'd0,   1'b1}, 1'b0, NO_DRAW},
		'{'{OP_WRITE,  15'd24,    16'h0fc5, 6'd0,  7'd0,   1'b0}, 1'b0, NO_DRAW},
		'{'{OP_RENDER, 15'd0,     16'h0000, 6'd0,  7'd24,  1'b0}, 1'b0, NO_DRAW},
		'{'{OP_WRITE,  15'd32767, 16'hffff, 6'd0,  7'd0,   1'b0}, 1'b1, NO_DRAW},
		'{'{OP_WRITE,  15'd1023,  16'h7abc, 6'd0,  7'd0,   1'b0}, 1'b0, NO_DRAW},
		'{'{OP_RENDER, 15'd0,     16'h0000, 6'd15, 7'd63,  1'b0}, 1'b0, NO_DRAW},
		'{'{OP_RENDER, 15'd0,     16'h0000, 6'd47, 7'd127, 1'b0}, 1'b0, NO_DRAW},
		'{'{OP_WRITE,  15'd1832,  16'h5555, 6'd0,  7'd0,   1'b0}, 1'b0, NO_DRAW}
	};

	tilemap_cell_fetch_and_place #(
		.TILE_COUNT   (TILE_COUNT),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.operation      (operation),
		.word_address   (word_address),
		.write_data     (write_data),
		.cell_row       (cell_row),
		.cell_column    (cell_column),
		.wanted_priority(wanted_priority),
		.empty          (empty),
		.pop            (pop),
		.draw_mode      (draw_mode),
		.tile_code      (tile_code),
		.palette_index  (palette_index),
		.palette_bank   (palette_bank),
		.screen_x       (screen_x),
		.screen_y       (screen_y),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Bit 15 of the main word hands over to the alternate word, taken whole
	function automatic logic [15:0] pick_scroll(logic [15:0] main_word, logic [15:0] alt_word);
		return main_word[15] ? alt_word : main_word;
	endfunction

	// Tile RAM word behind a map cell: quadrant picks the page nibble
	function automatic int cell_address(logic [5:0] row, logic [6:0] col);
		int quad;
		int page;
		quad = (row[5] ? 2 : 0) + (col[6] ? 1 : 0);
		page = int'((cfg_copy.page_select >> (4 * quad)) & 16'hf);
		return page * 2048 + ((int'(row) * 64) & 'h7ff) + int'(col[5:0]);
	endfunction

	// Fetch, filter, remap and place one map cell
	function automatic result_t place_cell(logic [5:0] row, logic [6:0] col, logic prio);
		result_t     r;
		logic [15:0] word;
		int          bank;
		int          code;
		int          d;
		int          x;
		int          y;
		int          wd;
		logic [1:0]  mode;
		r = NO_DRAW;
		word = map_words_copy[cell_address(row, col)];
		if (word[15] != prio)
			return r;
		bank = word[12] ? int'(cfg_copy.bank_map[7:4]) : int'(cfg_copy.bank_map[3:0]);
		code = (bank * 4096 + int'(word[11:0])) & (TILE_COUNT - 1);
		if (code == 0)
			return r;
		// wrapped X against the clamp, wrapped Y
		d = (int'(cfg_copy.clamp_offset) -
			int'(pick_scroll(cfg_copy.scroll_horizontal, cfg_copy.alt_scroll_horizontal))) & 'h3ff;
		x = int'(col) * 8 - d;
		if (x < -int'(cfg_copy.clamp_offset))
			x += 1024;
		y = int'(row) * 8 -
			int'(pick_scroll(cfg_copy.scroll_vertical, cfg_copy.alt_scroll_vertical) & 16'h1ff);
		if (y < -288)
			y += 512;
		wd = int'(cfg_copy.visible_width);
		if (x > 7 && x < wd - 8 && y > 7 && y <= SCREEN_HEIGHT - 8)
			mode = DRAW_FULL;
		else if (x > -8 && x < wd && y > -8 && y < SCREEN_HEIGHT)
			mode = DRAW_CLIP;
		else
			mode = DRAW_NONE;
		if (mode == DRAW_NONE)
			return r;
		r.draw_mode     = mode;
		r.tile_code     = code[12:0];
		r.palette_index = word[12:6];
		r.palette_bank  = word[12:11];
		r.screen_x      = x[10:0];
		r.screen_y      = y[9:0];
		return r;
	endfunction

	// Outcome of an accepted beat; a write updates the RAM copy
	function automatic result_t beat_outcome(cell_beat_t b);
		if (b.operation == OP_WRITE) begin
			map_words_copy[b.word_address] = b.write_data;
			word_written[b.word_address]   = 1'b1;
			return NO_DRAW;
		end
		return place_cell(b.cell_row, b.cell_column, b.wanted_priority);
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_count++;
		$display("%0t: mismatch: %s", $time, msg);
	endtask

	// Offer one beat after a random gap; expectation logged at acceptance
	task automatic send_beat(cell_beat_t b, bit typed, result_t want);
		result_t outcome;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push            <= 1'b1;
		operation       <= b.operation;
		word_address    <= b.word_address;
		write_data      <= b.write_data;
		cell_row        <= b.cell_row;
		cell_column     <= b.cell_column;
		wanted_priority <= b.wanted_priority;
		@(posedge clk);
		while (full !== 1'b0)
			@(posedge clk);
		outcome = beat_outcome(b);
		pending_results.push_back(typed ? want : outcome);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic random_write();
		cell_beat_t b;
		b = '0;
		b.operation       = OP_WRITE;
		b.word_address    = 15'($urandom);
		b.write_data      = 16'($urandom);
		b.cell_row        = 6'($urandom);
		b.cell_column     = 7'($urandom);
		b.wanted_priority = 1'($urandom);
		send_beat(b, 1'b0, NO_DRAW);
	endtask

	// Render, mostly near the visible window, preceded by a write when needed
	task automatic random_render();
		cell_beat_t  b;
		cell_beat_t  w;
		int          d;
		int          tx;
		int          ty;
		int          a;
		logic [15:0] tw;
		b = '0;
		b.operation    = OP_RENDER;
		b.word_address = 15'($urandom);
		b.write_data   = 16'($urandom);
		if ($urandom_range(0, 99) < 60) begin
			d = (int'(cfg_copy.clamp_offset) -
				int'(pick_scroll(cfg_copy.scroll_horizontal, cfg_copy.alt_scroll_horizontal)))
				& 'h3ff;
			tx = int'($urandom_range(0, 352)) - 16;
			ty = int'($urandom_range(0, 256)) - 16;
			b.cell_column = 7'((d + tx + 1024) >> 3);
			b.cell_row = 6'((int'(pick_scroll(cfg_copy.scroll_vertical,
				cfg_copy.alt_scroll_vertical) & 16'h1ff) + ty + 512) >> 3);
		end else begin
			b.cell_row    = 6'($urandom);
			b.cell_column = 7'($urandom);
		end
		a = cell_address(b.cell_row, b.cell_column);
		if (!word_written[a] || $urandom_range(0, 99) < 30) begin
			tw = 16'($urandom);
			if ($urandom_range(0, 99) < 6)
				tw[11:0] = '0;
			w = b;
			w.operation    = OP_WRITE;
			w.word_address = 15'(a);
			w.write_data   = tw;
			send_beat(w, 1'b0, NO_DRAW);
		end
		// mostly the matching priority, sometimes the other pass
		b.wanted_priority = map_words_copy[a][15] ^ ($urandom_range(0, 99) < 15);
		send_beat(b, 1'b0, NO_DRAW);
	endtask

	// Wait for every expected beat, then wait on with the inputs idle
	task automatic wait_idle();
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Write all eight registers back to back
	task automatic load_config(cfg_t c);
		logic [2:0]  idx;
		logic [15:0] val;
		for (int i = 0; i < 8; i++) begin
			idx = 3'(i);
			case (idx)
				REG_PAGE_SELECT:   val = c.page_select;
				REG_SCROLL_H:      val = c.scroll_horizontal;
				REG_SCROLL_V:      val = c.scroll_vertical;
				REG_ALT_SCROLL_H:  val = c.alt_scroll_horizontal;
				REG_ALT_SCROLL_V:  val = c.alt_scroll_vertical;
				REG_CLAMP_OFFSET:  val = 16'(c.clamp_offset);
				REG_VISIBLE_WIDTH: val = 16'(c.visible_width);
				default:           val = 16'(c.bank_map);
			endcase
			cfg_write <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= val;
			@(negedge clk);
		end
		cfg_write <= 1'b0;
		cfg_copy = c;
	endtask

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				pop <= 1'b0;
				repeat (hold_len) @(negedge clk);
				hold_len = 0;
			end else begin
				pop <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && pop === 1'b1 && empty === 1'b0) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing expected, draw_mode %0d",
					draw_mode));
			end else begin
				want = pending_results.pop_front();
				if (draw_mode !== want.draw_mode)
					report_mismatch($sformatf("draw_mode %0d, expected %0d",
						draw_mode, want.draw_mode));
				if (tile_code !== want.tile_code)
					report_mismatch($sformatf("tile_code %0h, expected %0h",
						tile_code, want.tile_code));
				if (palette_index !== want.palette_index)
					report_mismatch($sformatf("palette_index %0d, expected %0d",
						palette_index, want.palette_index));
				if (palette_bank !== want.palette_bank)
					report_mismatch($sformatf("palette_bank %0d, expected %0d",
						palette_bank, want.palette_bank));
				if (screen_x !== want.screen_x)
					report_mismatch($sformatf("screen_x %0d, expected %0d",
						screen_x, $signed(want.screen_x)));
				if (screen_y !== want.screen_y)
					report_mismatch($sformatf("screen_y %0d, expected %0d",
						screen_y, $signed(want.screen_y)));
			end
		end
	end

	// Run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// Main sequence
	initial begin
		cfg_t c;
		int   target;
		arst_n          = 1'b0;
		push            = 1'b0;
		operation       = OP_WRITE;
		word_address    = '0;
		write_data      = '0;
		cell_row        = '0;
		cell_column     = '0;
		wanted_priority = 1'b0;
		cfg_write       = 1'b0;
		cfg_index       = REG_PAGE_SELECT;
		cfg_data        = '0;
		beats_sent      = 0;
		mismatch_count  = 0;
		send_idle_pct   = 0;
		stall_pct       = 0;
		hold_len        = 0;
		cfg_copy        = '0;
		cfg_copy.clamp_offset  = RESET_CLAMP_OFFSET;
		cfg_copy.visible_width = RESET_VISIBLE_WIDTH;
		cfg_copy.bank_map      = RESET_BANK_MAP;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			// idle pattern of this phase
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 84; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 84; end
				default: begin send_idle_pct = 6; stall_pct = 6; end
			endcase

			if (ph > 0) begin
				wait_idle();
				c.page_select           = 16'($urandom);
				c.scroll_horizontal     = 16'($urandom);
				c.scroll_vertical       = 16'($urandom);
				c.alt_scroll_horizontal = 16'($urandom);
				c.alt_scroll_vertical   = 16'($urandom);
				c.clamp_offset          = 10'($urandom);
				c.visible_width         = 10'($urandom_range(8, 1023));
				c.bank_map              = 8'($urandom);
				case (ph)
					1: c = '0;
					2: c = '1;
					5: c.visible_width = 10'd8;
					7: c.visible_width = 10'($urandom_range(0, 7));
					default: ;
				endcase
				load_config(c);
			end

			if (ph == 0)
				for (int i = 0; i < DIR_ROWS; i++)
					send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

			// back-pressure: long receiver hold while the sender keeps going
			if (ph == 4)
				hold_len = 400;

			target = beats_sent + RAND_PER_PHASE;
			while (beats_sent < target) begin
				if ($urandom_range(0, 99) < 12)
					random_write();
				else
					random_render();
			end
			push <= 1'b0;
		end

		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: files.f
src/tcfp_pkg.sv
src/tcfp_fifo.sv
src/tcfp_front.sv
src/tcfp_back.sv
src/tilemap_cell_fetch_and_place.sv
dv/tb_tilemap_cell_fetch_and_place.sv
